FILE: hw/rtl/aea_pkg.sv
package aea_pkg;

  typedef enum logic [2:0] {
    PH_ATTACK   = 3'd0,
    PH_HOLD     = 3'd1,
    PH_DECAY    = 3'd2,
    PH_SUSTAIN  = 3'd3,
    PH_RELEASE  = 3'd4,
    PH_FINISHED = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    FN_TICK     = 2'd0,
    FN_NOTE_ON  = 2'd1,
    FN_RELEASE  = 2'd2,
    FN_RESERVED = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_HOLD    = 3'd1,
    REG_DECAY   = 3'd2,
    REG_SUSTAIN = 3'd3,
    REG_RELEASE = 3'd4,
    REG_ZONE    = 3'd5,
    REG_SPARE6  = 3'd6,
    REG_SPARE7  = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_NOTE_MUL,
    OP_NOTE_FIN,
    OP_LVL_FIXED,
    OP_DIV_ATK,
    OP_ATK_FIN,
    OP_DIV_IDX,
    OP_EXP_INIT,
    OP_EXP_STEP,
    OP_EXP_FIN,
    OP_REL_LATCH,
    OP_GAIN,
    OP_SCALE_L,
    OP_SCALE_R,
    OP_ADVANCE
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_NOTE_WAIT,
    S_LVL,
    S_ATK_WAIT,
    S_IDX_WAIT,
    S_EXP,
    S_EXP_FIN,
    S_USE,
    S_SCL_L,
    S_SCL_R,
    S_ADV
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    func_t  func;
    phase_t phase;
    logic   dur_zero;
    logic   div_done;
    logic   k_last;
    logic   out_busy;
  } dp_status_t;

  localparam int          LEVEL_W   = 17;
  localparam int          ACC_W     = 21;
  localparam int          VEL_W     = 7;
  localparam int          SUS_W     = 17;
  localparam int          ZONE_W    = 18;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [20:0] EXP_L     = 21'd1088529;
  localparam logic [20:0] ACC_ONE   = 21'h100000;
  // floor(x / 127) = (x * DIV127_MUL) >> DIV127_SH for x below 2^25
  localparam int          DIV127_W  = 26;
  localparam int          DIV127_SH = 32;
  localparam logic [25:0] DIV127_MUL = 26'd33818641;

  // 2^(-2^-(k+1)) in Q0.20
  function automatic logic [19:0] pow2_neg_frac(input logic [3:0] k);
    logic [19:0] c;
    case (k)
      4'd0:    c = 20'd741455;
      4'd1:    c = 20'd881744;
      4'd2:    c = 20'd961548;
      4'd3:    c = 20'd1004120;
      4'd4:    c = 20'd1026107;
      4'd5:    c = 20'd1037281;
      4'd6:    c = 20'd1042913;
      4'd7:    c = 20'd1045741;
      4'd8:    c = 20'd1047157;
      4'd9:    c = 20'd1047866;
      4'd10:   c = 20'd1048221;
      4'd11:   c = 20'd1048399;
      4'd12:   c = 20'd1048487;
      4'd13:   c = 20'd1048532;
      4'd14:   c = 20'd1048554;
      default: c = 20'd1048565;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/aea_div.sv
module aea_div #(
  parameter int DW = 40,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   shifted;
  logic [VW+1:0] trial;
  logic          ge;

  assign shifted  = {rem, quo[DW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dvs};
  assign ge       = !trial[VW+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[VW-1:0] : shifted[VW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");

endmodule

FILE: hw/rtl/aea_dp.sv
module aea_dp #(
  parameter int TIME_BITS      = 24,
  parameter int SAMPLE_BITS    = 24,
  parameter int EXP_TABLE_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  aea_pkg::dp_cmd_t              cmd,
  output aea_pkg::dp_status_t           status,
  input  logic [1:0]                    func,
  input  logic [aea_pkg::VEL_W-1:0]     velocity,
  input  logic [SAMPLE_BITS-1:0]        in_left,
  input  logic [SAMPLE_BITS-1:0]        in_right,
  input  logic                          source_done,
  input  logic [TIME_BITS-1:0]          attack_ticks,
  input  logic [TIME_BITS-1:0]          hold_ticks,
  input  logic [TIME_BITS-1:0]          decay_ticks,
  input  logic [aea_pkg::SUS_W-1:0]     sustain_level,
  input  logic [TIME_BITS-1:0]          release_ticks,
  input  logic [aea_pkg::ZONE_W-1:0]    zone_gain,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [SAMPLE_BITS-1:0]        out_left,
  output logic [SAMPLE_BITS-1:0]        out_right,
  output logic [2:0]                    out_phase,
  output logic                          out_done
);
  import aea_pkg::*;

  localparam int TW    = TIME_BITS;
  localparam int SW    = SAMPLE_BITS;
  localparam int ETS_W = $clog2(EXP_TABLE_SIZE + 1);
  localparam int DW    = TW + 16;
  localparam int VW    = TW;
  localparam int PW    = SW + 18;
  localparam int EW    = ETS_W + ACC_W;
  localparam int NP_W  = ZONE_W + VEL_W;
  localparam int NQ_W  = NP_W + DIV127_W;

  logic [1:0]          func_q;
  logic [VEL_W-1:0]    vel_q;
  logic [SW-1:0]       left_q;
  logic [SW-1:0]       right_q;
  logic                src_q;
  phase_t              env_phase;
  phase_t              phase_next;
  logic [TW-1:0]       phase_timer;
  logic [TW-1:0]       timer_next;
  logic [TW-1:0]       timer_inc;
  logic [LEVEL_W-1:0]  rsl;
  logic [LEVEL_W-1:0]  note_gain;
  logic [LEVEL_W-1:0]  lvl;
  logic [LEVEL_W-1:0]  g;
  logic [ACC_W-1:0]    e_q;
  logic [ACC_W-1:0]    acc;
  logic [3:0]          k;
  logic [SW-1:0]       prod_l;
  logic [SW-1:0]       prod_r;
  logic [NP_W-1:0]     note_prod;

  logic [LEVEL_W-1:0]  sus;
  logic [TW-1:0]       dur;
  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [VW-1:0]       div_divisor;
  logic                div_done;
  logic [DW-1:0]       q;
  logic [ETS_W-1:0]    idx;
  logic [LEVEL_W-1:0]  exp_v;
  logic [LEVEL_W-1:0]  q_lvl;
  logic [4:0]          exp_sh;
  logic [ZONE_W-1:0]   note_div;
  logic [LEVEL_W-1:0]  note_lvl;

  function automatic logic [SW-1:0] scale(input logic [SW-1:0] s, input logic [LEVEL_W-1:0] gv);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] adj;
    p   = PW'($signed(s)) * $signed({1'b0, gv});
    adj = p[PW-1] ? p + PW'(65535) : p;
    return SW'(adj >>> 16);
  endfunction

  assign sus = (sustain_level > ONE_Q16) ? ONE_Q16 : sustain_level;

  always_comb begin
    case (env_phase)
      PH_ATTACK:  dur = attack_ticks;
      PH_DECAY:   dur = decay_ticks;
      PH_RELEASE: dur = release_ticks;
      default:    dur = hold_ticks;
    endcase
  end

  assign idx      = (q > DW'(EXP_TABLE_SIZE)) ? ETS_W'(EXP_TABLE_SIZE) : q[ETS_W-1:0];
  assign q_lvl    = (q > DW'(ONE_Q16)) ? ONE_Q16 : q[LEVEL_W-1:0];
  assign exp_sh   = e_q[20:16] + 5'd4;
  assign exp_v    = LEVEL_W'(acc >> exp_sh);
  assign note_div = ZONE_W'((NQ_W'(note_prod) * NQ_W'(DIV127_MUL)) >> DIV127_SH);
  assign note_lvl = (note_div > ZONE_W'(ONE_Q16)) ? ONE_Q16 : note_div[LEVEL_W-1:0];

  always_comb begin
    div_start    = 1'b1;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd.op)
      OP_DIV_ATK: begin
        div_dividend = DW'({phase_timer, 16'h0000});
        div_divisor  = VW'(attack_ticks);
      end
      OP_DIV_IDX: begin
        div_dividend = DW'(phase_timer) * DW'(EXP_TABLE_SIZE);
        div_divisor  = VW'(dur);
      end
      default: div_start = 1'b0;
    endcase
  end

  aea_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (q)
  );

  always_comb begin
    phase_next = env_phase;
    timer_next = phase_timer;
    timer_inc  = phase_timer;
    if (env_phase != PH_SUSTAIN && phase_timer != {TW{1'b1}}) begin
      timer_inc = phase_timer + 1'b1;
    end
    if (env_phase != PH_FINISHED) begin
      if (src_q) begin
        phase_next = PH_FINISHED;
      end else begin
        timer_next = timer_inc;
        case (env_phase)
          PH_ATTACK: if (timer_inc >= attack_ticks) begin
            phase_next = PH_HOLD;
            timer_next = '0;
          end
          PH_HOLD: if (timer_inc >= hold_ticks) begin
            phase_next = PH_DECAY;
            timer_next = '0;
          end
          PH_DECAY: if (timer_inc >= decay_ticks) begin
            phase_next = (sus == '0) ? PH_FINISHED : PH_SUSTAIN;
            timer_next = '0;
          end
          PH_RELEASE: if (timer_inc >= release_ticks) begin
            phase_next = PH_FINISHED;
            timer_next = '0;
          end
          default: ;
        endcase
      end
    end
  end

  // control state of the voice
  always_ff @(posedge clk) begin
    if (rst) begin
      env_phase   <= PH_FINISHED;
      phase_timer <= '0;
      rsl         <= '0;
      note_gain   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.op == OP_ADVANCE) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_NOTE_FIN: begin
          note_gain   <= note_lvl;
          env_phase   <= PH_ATTACK;
          phase_timer <= '0;
          rsl         <= sus;
        end
        OP_REL_LATCH: begin
          rsl         <= lvl;
          phase_timer <= '0;
          env_phase   <= PH_RELEASE;
        end
        OP_ADVANCE: begin
          env_phase   <= phase_next;
          phase_timer <= timer_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        func_q  <= func;
        vel_q   <= velocity;
        left_q  <= in_left;
        right_q <= in_right;
        src_q   <= source_done;
      end
      OP_NOTE_MUL: note_prod <= NP_W'(zone_gain) * NP_W'(vel_q);
      OP_LVL_FIXED: begin
        case (env_phase)
          PH_ATTACK, PH_HOLD, PH_DECAY: lvl <= ONE_Q16;
          PH_SUSTAIN:                   lvl <= sus;
          PH_RELEASE:                   lvl <= rsl;
          default:                      lvl <= '0;
        endcase
      end
      OP_ATK_FIN: lvl <= q_lvl;
      OP_EXP_INIT: begin
        e_q <= ACC_W'((EW'(idx) * EW'(EXP_L)) / EW'(EXP_TABLE_SIZE));
        acc <= ACC_ONE;
        k   <= '0;
      end
      OP_EXP_STEP: begin
        if (e_q[4'd15 - k]) begin
          acc <= ACC_W'((41'(acc) * 41'(pow2_neg_frac(k))) >> 20);
        end
        k <= k + 1'b1;
      end
      OP_EXP_FIN: begin
        if (env_phase == PH_DECAY) begin
          lvl <= (exp_v < sus) ? sus : exp_v;
        end else begin
          lvl <= LEVEL_W'((34'(rsl) * 34'(exp_v)) >> 16);
        end
      end
      OP_GAIN:    g      <= LEVEL_W'((34'(lvl) * 34'(note_gain)) >> 16);
      OP_SCALE_L: prod_l <= scale(left_q, g);
      OP_SCALE_R: prod_r <= scale(right_q, g);
      OP_ADVANCE: begin
        out_left  <= prod_l;
        out_right <= prod_r;
        out_phase <= phase_next;
        out_done  <= (phase_next == PH_FINISHED);
      end
      default: ;
    endcase
  end

  assign status.func     = func_t'(func_q);
  assign status.phase    = env_phase;
  assign status.dur_zero = (dur == '0);
  assign status.div_done = div_done;
  assign status.k_last   = (k == 4'd15);
  assign status.out_busy = out_valid && !out_ready;

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_NOTE_FIN) |=> (env_phase == PH_ATTACK && phase_timer == '0))
    else $error("note on did not restart attack");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ADVANCE) |=> out_valid && out_done == (env_phase == PH_FINISHED))
    else $error("result phase differs from voice phase");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EXP_FIN) |-> e_q <= EXP_L)
    else $error("exponent out of range");

endmodule

FILE: hw/rtl/aea_ctrl.sv
module aea_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output aea_pkg::dp_cmd_t    cmd,
  input  aea_pkg::dp_status_t status
);
  import aea_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.func)
          FN_NOTE_ON: begin
            cmd.op     = OP_NOTE_MUL;
            state_next = S_NOTE_WAIT;
          end
          FN_RELEASE: state_next = (status.phase == PH_FINISHED) ? S_IDLE : S_LVL;
          FN_TICK:    state_next = S_LVL;
          default:    state_next = S_IDLE;
        endcase
      end
      S_NOTE_WAIT: begin
        cmd.op     = OP_NOTE_FIN;
        state_next = S_IDLE;
      end
      S_LVL: begin
        if (status.phase == PH_ATTACK && !status.dur_zero) begin
          cmd.op     = OP_DIV_ATK;
          state_next = S_ATK_WAIT;
        end else if ((status.phase == PH_DECAY || status.phase == PH_RELEASE) &&
                     !status.dur_zero) begin
          cmd.op     = OP_DIV_IDX;
          state_next = S_IDX_WAIT;
        end else begin
          cmd.op     = OP_LVL_FIXED;
          state_next = S_USE;
        end
      end
      S_ATK_WAIT: if (status.div_done) begin
        cmd.op     = OP_ATK_FIN;
        state_next = S_USE;
      end
      S_IDX_WAIT: if (status.div_done) begin
        cmd.op     = OP_EXP_INIT;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.op = OP_EXP_STEP;
        if (status.k_last) begin
          state_next = S_EXP_FIN;
        end
      end
      S_EXP_FIN: begin
        cmd.op     = OP_EXP_FIN;
        state_next = S_USE;
      end
      S_USE: begin
        if (status.func == FN_RELEASE) begin
          cmd.op     = OP_REL_LATCH;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_GAIN;
          state_next = S_SCL_L;
        end
      end
      S_SCL_L: begin
        cmd.op     = OP_SCALE_L;
        state_next = S_SCL_R;
      end
      S_SCL_R: begin
        cmd.op     = OP_SCALE_R;
        state_next = S_ADV;
      end
      S_ADV: if (!status.out_busy) begin
        cmd.op     = OP_ADVANCE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DISPATCH)
    else $error("accepted request not dispatched");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ADVANCE) |-> !status.out_busy)
    else $error("result overwritten while still held");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP && !status.k_last) |=> state == S_EXP)
    else $error("exponent loop left early");

endmodule

FILE: hw/rtl/ahdsr_envelope_amplifier.sv
// One voice of an attack-hold-decay-sustain-release amplifier on stream ports. A request with
// tuser = 1 (note on) sets the note gain from zone_gain and velocity and restarts the attack;
// tuser = 2 latches the current level and starts the release; tuser = 0 (tick) returns one
// result: the stereo pair scaled by level times note gain, with the phase after the step.
// Requests are worked one at a time and the input is not ready until the current one is done.
// Each request passes the dispatch state first. A note on then runs the note multiply and latches
// the gain; a tick in hold, sustain or finished (or with a zero duration) takes a fixed level; a
// tick in attack runs one divide; a tick in decay or release runs one divide plus sixteen
// exponent steps; the serial divider gives one quotient bit per cycle over DW = TIME_BITS + 16.
// A release request ends once the level is known, before a tick's gain and scaling steps. A tick
// also waits while the previous result is still held on the output.
// Config registers are written over APB at byte address 4 * index and read back the same way.
module ahdsr_envelope_amplifier #(
  parameter int TIME_BITS      = 24,
  parameter int SAMPLE_BITS    = 24,
  parameter int EXP_TABLE_SIZE = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // velocity, in_left, in_right, source_done
  input  logic [((2*SAMPLE_BITS+8+7)/8)*8-1:0]   s_tdata,
  // func
  input  logic [1:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // out_left, out_right, phase, voice_done
  output logic [((2*SAMPLE_BITS+4+7)/8)*8-1:0]   m_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [4:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import aea_pkg::*;

  localparam int SW    = SAMPLE_BITS;
  localparam int TW    = TIME_BITS;
  localparam int OUT_W = ((2*SW+4+7)/8)*8;

  logic [TW-1:0]     attack_ticks;
  logic [TW-1:0]     hold_ticks;
  logic [TW-1:0]     decay_ticks;
  logic [SUS_W-1:0]  sustain_level;
  logic [TW-1:0]     release_ticks;
  logic [ZONE_W-1:0] zone_gain;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [SW-1:0]     out_left;
  logic [SW-1:0]     out_right;
  logic [2:0]        out_phase;
  logic              out_done;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= '0;
      hold_ticks    <= '0;
      decay_ticks   <= '0;
      sustain_level <= ONE_Q16;
      release_ticks <= '0;
      zone_gain     <= ZONE_W'(ONE_Q16);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ATTACK:  attack_ticks  <= pwdata[TW-1:0];
        REG_HOLD:    hold_ticks    <= pwdata[TW-1:0];
        REG_DECAY:   decay_ticks   <= pwdata[TW-1:0];
        REG_SUSTAIN: sustain_level <= pwdata[SUS_W-1:0];
        REG_RELEASE: release_ticks <= pwdata[TW-1:0];
        REG_ZONE:    zone_gain     <= pwdata[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:  prdata = 32'(attack_ticks);
      REG_HOLD:    prdata = 32'(hold_ticks);
      REG_DECAY:   prdata = 32'(decay_ticks);
      REG_SUSTAIN: prdata = 32'(sustain_level);
      REG_RELEASE: prdata = 32'(release_ticks);
      REG_ZONE:    prdata = 32'(zone_gain);
      default:     prdata = '0;
    endcase
  end

  aea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  aea_dp #(
    .TIME_BITS      (TIME_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (s_tuser),
    .velocity      (s_tdata[VEL_W-1:0]),
    .in_left       (s_tdata[SW+VEL_W-1:VEL_W]),
    .in_right      (s_tdata[2*SW+VEL_W-1:SW+VEL_W]),
    .source_done   (s_tdata[2*SW+VEL_W]),
    .attack_ticks  (attack_ticks),
    .hold_ticks    (hold_ticks),
    .decay_ticks   (decay_ticks),
    .sustain_level (sustain_level),
    .release_ticks (release_ticks),
    .zone_gain     (zone_gain),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_left      (out_left),
    .out_right     (out_right),
    .out_phase     (out_phase),
    .out_done      (out_done)
  );

  assign m_tdata = OUT_W'({out_done, out_phase, out_right, out_left});

endmodule
